// File: design/mcsq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcsq_pkg
// Shared codes, state encoding and controller command bundle for the
// multi-context stack and queue table.
// ----------------------------------------------------------------------------
package mcsq_pkg;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_PUSH   = 2'd1,
    OP_POP    = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EXISTS  = 3'd1,
    ST_NO_NAME = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  localparam logic KIND_QUEUE = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_DONE = 2'd2
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

endpackage : mcsq_pkg
`default_nettype wire

// File: design/mcsq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcsq_ctrl
// Command sequencer: capture a transaction, run the context update, then
// present the result strobe while taking the next transaction.
// ----------------------------------------------------------------------------
module mcsq_ctrl
  import mcsq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  output logic      out_valid,
  output ctrl_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    busy      = 1'b0;
    out_valid = 1'b0;
    cmd.load  = 1'b0;
    cmd.exec  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        cmd.load = start;
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        busy      = 1'b1;
        cmd.exec  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        out_valid = 1'b1;
        cmd.load  = start;
        state_nxt = start ? S_EXEC : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> ($past(state_r) == S_EXEC))
    else $error("result strobe without a preceding update");

  a_load_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (cmd.exec && busy))
    else $error("captured transaction not executed");

endmodule : mcsq_ctrl
`default_nettype wire

// File: design/mcsq_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcsq_dp
// Datapath: context table memory with valid bits, slot memory, pointer
// arithmetic and result registers.
// ----------------------------------------------------------------------------
module mcsq_dp
  import mcsq_pkg::*;
#(
  parameter int NUM_LISTS = 16,
  parameter int DEPTH     = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ctrl_cmd_t          cmd,
  input  wire logic        [1:0]  in_operation,
  input  wire logic        [3:0]  in_list_id,
  input  wire logic               in_list_kind,
  input  wire logic signed [31:0] in_push_value,
  output logic             [2:0]  out_status,
  output logic signed      [31:0] out_popped_value,
  output logic                    out_popped_valid
);

  localparam int IDW   = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int FW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int EW    = 1 + FW + CW;
  localparam int SLOTS = NUM_LISTS * DEPTH;
  localparam int AW    = $clog2(SLOTS);

  logic [EW-1:0] ctx_mem [NUM_LISTS];
  logic [31:0]   slot_mem [SLOTS];

  logic [NUM_LISTS-1:0] valid_r;

  logic [1:0]     op_r;
  logic [IDW-1:0] idx_r;
  logic           kind_r;
  logic [31:0]    word_r;
  logic           intab_r;
  logic           exists_r;
  logic [EW-1:0]  ctx_r;
  logic [31:0]    slot_r;
  status_t        status_r;
  logic           got_r;

  logic           in_table;
  logic [IDW-1:0] idx_in;

  logic           cq_kind;
  logic [FW-1:0]  cq_front;
  logic [CW-1:0]  cq_count;
  logic [FW:0]    sum_push;
  logic [FW:0]    sum_top;
  logic [FW-1:0]  push_pos;
  logic [FW-1:0]  top_pos;
  logic [FW-1:0]  front_inc;

  status_t        status_nxt;
  logic           got_nxt;
  logic           ctx_we;
  logic [EW-1:0]  ctx_wd;
  logic           valid_set;
  logic           slot_we;
  logic           slot_re;
  logic [FW-1:0]  pos;
  logic [AW-1:0]  slot_addr;

  assign in_table = ({28'd0, in_list_id} < 32'(NUM_LISTS));
  assign idx_in   = IDW'(in_list_id);

  // capture transaction and fetch context
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_operation;
      idx_r    <= idx_in;
      kind_r   <= in_list_kind;
      word_r   <= in_push_value;
      intab_r  <= in_table;
      exists_r <= in_table & valid_r[idx_in];
      ctx_r    <= ctx_mem[idx_in];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.exec && valid_set) begin
      valid_r[idx_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && ctx_we) begin
      ctx_mem[idx_r] <= ctx_wd;
    end
  end

  assign cq_kind  = ctx_r[EW-1];
  assign cq_front = ctx_r[CW +: FW];
  assign cq_count = ctx_r[CW-1:0];

  always_comb begin
    sum_push  = (FW+1)'(cq_front) + (FW+1)'(cq_count);
    sum_top   = sum_push - (FW+1)'(1);
    push_pos  = (sum_push >= (FW+1)'(DEPTH)) ? FW'(sum_push - (FW+1)'(DEPTH))
                                             : FW'(sum_push);
    top_pos   = (sum_top >= (FW+1)'(DEPTH)) ? FW'(sum_top - (FW+1)'(DEPTH))
                                            : FW'(sum_top);
    front_inc = (cq_front == FW'(DEPTH - 1)) ? '0 : cq_front + FW'(1);
  end

  always_comb begin
    status_nxt = ST_OK;
    got_nxt    = 1'b0;
    ctx_we     = 1'b0;
    ctx_wd     = ctx_r;
    valid_set  = 1'b0;
    slot_we    = 1'b0;
    slot_re    = 1'b0;
    pos        = push_pos;
    unique case (op_r)
      OP_CREATE: begin
        if (!intab_r) begin
          status_nxt = ST_FULL;
        end else if (exists_r) begin
          status_nxt = ST_EXISTS;
        end else begin
          ctx_we    = 1'b1;
          valid_set = 1'b1;
          ctx_wd    = {kind_r, {FW{1'b0}}, {CW{1'b0}}};
        end
      end
      OP_PUSH: begin
        if (!exists_r) begin
          status_nxt = ST_NO_NAME;
        end else if (cq_count == CW'(DEPTH)) begin
          status_nxt = ST_FULL;
        end else begin
          slot_we = 1'b1;
          ctx_we  = 1'b1;
          ctx_wd  = {cq_kind, cq_front, cq_count + CW'(1)};
        end
      end
      OP_POP: begin
        if (!exists_r) begin
          status_nxt = ST_NO_NAME;
        end else if (cq_count == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          slot_re = 1'b1;
          got_nxt = 1'b1;
          ctx_we  = 1'b1;
          if (cq_kind == KIND_QUEUE) begin
            pos    = cq_front;
            ctx_wd = {cq_kind, front_inc, cq_count - CW'(1)};
          end else begin
            pos    = top_pos;
            ctx_wd = {cq_kind, cq_front, cq_count - CW'(1)};
          end
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  assign slot_addr = AW'(idx_r) * AW'(DEPTH) + AW'(pos);

  always_ff @(posedge clk) begin
    if (cmd.exec && slot_we) begin
      slot_mem[slot_addr] <= word_r;
    end
    if (cmd.exec && slot_re) begin
      slot_r <= slot_mem[slot_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= ST_OK;
      got_r    <= 1'b0;
    end else if (cmd.exec) begin
      status_r <= status_nxt;
      got_r    <= got_nxt;
    end
  end

  assign out_status       = status_r;
  assign out_popped_valid = got_r;
  assign out_popped_value = got_r ? signed'(slot_r) : '0;

  a_got_ok: assert property (@(posedge clk) disable iff (!rst_n)
    got_r |-> (status_r == ST_OK))
    else $error("popped word with a failing status");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && ctx_we) |-> (ctx_wd[CW-1:0] <= CW'(DEPTH)))
    else $error("list count beyond depth");

  a_slot_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> !(slot_we && slot_re))
    else $error("slot read and write in one update");

endmodule : mcsq_dp
`default_nettype wire

// File: design/multi_context_stack_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multi_context_stack_queue
// Table of list contexts, each a stack or a queue over its own slot buffer.
// ----------------------------------------------------------------------------
// Sequence: an accepted command is captured with its context read, then
//   runs its context update with its single slot memory access in S_EXEC;
//   its result is strobed in S_DONE. A new command is taken in the cycle
//   the previous result is strobed, but not while busy in S_EXEC.
// Reset: clears all list valid bits at once; no clearing pass.
// Results cannot be stalled: one strobed result per command.
module multi_context_stack_queue
  import mcsq_pkg::*;
#(
  parameter int NUM_LISTS = 16,
  parameter int DEPTH     = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic        [1:0]  in_operation,
  input  wire logic        [3:0]  in_list_id,
  input  wire logic               in_list_kind,
  input  wire logic signed [31:0] in_push_value,
  output logic                    out_valid,
  output logic             [2:0]  out_status,
  output logic signed      [31:0] out_popped_value,
  output logic                    out_popped_valid
);

  ctrl_cmd_t cmd;

  mcsq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  mcsq_dp #(
    .NUM_LISTS (NUM_LISTS),
    .DEPTH     (DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_operation     (in_operation),
    .in_list_id       (in_list_id),
    .in_list_kind     (in_list_kind),
    .in_push_value    (in_push_value),
    .out_status       (out_status),
    .out_popped_value (out_popped_value),
    .out_popped_valid (out_popped_valid)
  );

endmodule : multi_context_stack_queue
`default_nettype wire
